FILE: hdl/cell_list_binning_core_assert.svh
// ----------------------------------------------------------------------------
// Cell list binning core: assertion macros
// Concurrent assertion helpers shared by the RTL files. They expand to
// nothing when the code is read for synthesis.
// ----------------------------------------------------------------------------
`ifndef CELL_LIST_BINNING_CORE_ASSERT_SVH
`define CELL_LIST_BINNING_CORE_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`ifndef SYNTHESIS
`define CLB_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("clb: assertion failed");
`else
`define CLB_ASSERT(lbl, clk, rst_n, prop)
`endif

// A condition that must never be seen at a clock edge outside reset.
`ifndef SYNTHESIS
`define CLB_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("clb: forbidden condition seen");
`else
`define CLB_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

FILE: hdl/clb_pkg.sv
// ----------------------------------------------------------------------------
// Cell list binning package
// Fixed field widths, command and register codes, controller states and
// the status bundle passed from the binning pipeline to the controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package clb_pkg;

  // Field widths of the command and result items.
  localparam int unsigned POS_W      = 24;
  localparam int unsigned RECIP_W    = 24;
  localparam int unsigned CPD_W      = 5;
  localparam int unsigned ATOM_IDX_W = 12;
  localparam int unsigned CELL_IDX_W = 12;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 24;

  // Width of a Q8.16 by Q8.16 product (Q16.32) and of its integer part.
  localparam int unsigned PROD_W     = POS_W + RECIP_W;
  localparam int unsigned AXIS_RAW_W = 16;

  // Command modes.
  localparam logic MODE_CLEAR  = 1'b0;
  localparam logic MODE_INSERT = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_CELLS_PER_DIM     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RECIP_CELL_LENGTH = 1'b1;

  // Configuration reset values.
  localparam logic [CPD_W-1:0]   CPD_RESET   = 5'd16;
  localparam logic [RECIP_W-1:0] RECIP_RESET = 24'd65536;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_BIN,
    ST_LOOKUP
  } clb_state_e;

  // Status of the binning pipeline.
  typedef struct packed {
    logic done;
    logic clamped;
  } clb_bin_stat_t;

endpackage

`default_nettype wire

FILE: hdl/clb_head_ram.sv
// ----------------------------------------------------------------------------
// Cell head memory
// Simple dual-port synchronous RAM: one write port and one read port with
// the read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module clb_head_ram #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned WIDTH = 13,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/clb_bin_calc.sv
// ----------------------------------------------------------------------------
// Binning pipeline
// Four stages: scale the coordinates by the reciprocal cell length, floor
// and saturate each axis, then fold the axes into a flat cell index with
// one multiply per stage. The atom index is reduced to the atom store
// depth alongside.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module clb_bin_calc
  import clb_pkg::*;
#(
  parameter int unsigned MAX_CELLS_PER_DIM = 16,
  parameter int unsigned MAX_ATOMS         = 4096,
  localparam int unsigned N_W    = $clog2(MAX_CELLS_PER_DIM + 1),
  localparam int unsigned AX_W   = (MAX_CELLS_PER_DIM > 1) ? $clog2(MAX_CELLS_PER_DIM) : 1,
  localparam int unsigned U_W    = (MAX_CELLS_PER_DIM > 1) ?
                                   $clog2(MAX_CELLS_PER_DIM * MAX_CELLS_PER_DIM) : 1,
  localparam int unsigned CELL_W = (MAX_CELLS_PER_DIM > 1) ?
                                   $clog2(MAX_CELLS_PER_DIM ** 3) : 1,
  localparam int unsigned ATOM_W = $clog2(MAX_ATOMS)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [ATOM_IDX_W-1:0] atom_index_i,
  input  wire logic [POS_W-1:0]      pos_x_i,
  input  wire logic [POS_W-1:0]      pos_y_i,
  input  wire logic [POS_W-1:0]      pos_z_i,
  input  wire logic [RECIP_W-1:0]    recip_i,
  input  wire logic [N_W-1:0]        n_i,
  output clb_bin_stat_t              stat_o,
  output logic      [CELL_W-1:0]     cell_o,
  output logic      [ATOM_W-1:0]     atom_o
);

  localparam int unsigned P_W = N_W + AX_W;
  localparam int unsigned Q_W = N_W + U_W;

  logic [3:0] vld_q;

  logic [2:0][POS_W-1:0]      pos;
  logic [2:0][PROD_W-1:0]     prod;
  logic [2:0][AXIS_RAW_W-1:0] raw_q;
  logic [ATOM_IDX_W-1:0]      atom1_q;

  logic [N_W-1:0]        nm1;
  logic [2:0]            hit;
  logic [2:0][AX_W-1:0]  ax_d;
  logic [2:0][AX_W-1:0]  ax_q;
  logic                  clamp2_q;
  logic [ATOM_W-1:0]     atom2_d;
  logic [ATOM_W-1:0]     atom2_q;

  logic [P_W-1:0]        n_iz;
  logic [U_W-1:0]        u_q;
  logic [AX_W-1:0]       ax3_q;
  logic                  clamp3_q;
  logic [ATOM_W-1:0]     atom3_q;

  logic [Q_W-1:0]        n_u;
  logic [CELL_W-1:0]     cell_q;
  logic                  clamp4_q;
  logic [ATOM_W-1:0]     atom4_q;

  // Stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], start_i};
    end
  end

  // Stage 1: scale each coordinate; the integer part of the Q16.32 product.
  assign pos = {pos_z_i, pos_y_i, pos_x_i};

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod[k] = PROD_W'(pos[k]) * PROD_W'(recip_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      for (int k = 0; k < 3; k++) begin
        raw_q[k] <= prod[k][PROD_W-1 -: AXIS_RAW_W];
      end
      atom1_q <= atom_index_i;
    end
  end

  // Atom index reduction to the atom store depth.
  if (MAX_ATOMS >= (2 ** ATOM_IDX_W)) begin : g_atom_pass
    assign atom2_d = ATOM_W'(atom1_q);
  end else begin : g_atom_wrap
    // Reciprocal with enough fraction bits that the quotient is exact for
    // every 12-bit index, so no correction step is needed.
    localparam int unsigned RS = 24;
    localparam logic [RS-1:0] RECIP_M = RS'(((2 ** RS) + MAX_ATOMS - 1) / MAX_ATOMS);

    logic [ATOM_IDX_W+RS-1:0] qprod;
    logic [ATOM_IDX_W-1:0]    quot_q;
    logic [ATOM_IDX_W+RS-1:0] qm;
    logic [ATOM_IDX_W-1:0]    rem;

    assign qprod = (ATOM_IDX_W+RS)'(atom_index_i) * (ATOM_IDX_W+RS)'(RECIP_M);

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        quot_q <= qprod[ATOM_IDX_W+RS-1 -: ATOM_IDX_W];
      end
    end

    assign qm      = (ATOM_IDX_W+RS)'(quot_q) * (ATOM_IDX_W+RS)'(MAX_ATOMS);
    assign rem     = atom1_q - qm[ATOM_IDX_W-1:0];
    assign atom2_d = ATOM_W'(rem);
  end

  // Stage 2: floor is already taken; saturate each axis at n-1.
  assign nm1 = n_i - 1'b1;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      hit[k] = (raw_q[k] >= AXIS_RAW_W'(n_i));
      if (hit[k]) begin
        ax_d[k] = AX_W'(nm1);
      end else begin
        ax_d[k] = AX_W'(raw_q[k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_q[0]) begin
      ax_q     <= ax_d;
      clamp2_q <= |hit;
      atom2_q  <= atom2_d;
    end
  end

  // Stage 3: u = y + n * z.
  assign n_iz = P_W'(n_i) * P_W'(ax_q[2]);

  always_ff @(posedge clk_i) begin
    if (vld_q[1]) begin
      u_q      <= U_W'(ax_q[1]) + U_W'(n_iz);
      ax3_q    <= ax_q[0];
      clamp3_q <= clamp2_q;
      atom3_q  <= atom2_q;
    end
  end

  // Stage 4: cell = x + n * u.
  assign n_u = Q_W'(n_i) * Q_W'(u_q);

  always_ff @(posedge clk_i) begin
    if (vld_q[2]) begin
      cell_q   <= CELL_W'(ax3_q) + CELL_W'(n_u);
      clamp4_q <= clamp3_q;
      atom4_q  <= atom3_q;
    end
  end

  // Cell, atom and clamp results hold until the next item reaches stage 4.
  assign stat_o.done    = vld_q[3];
  assign stat_o.clamped = clamp4_q;
  assign cell_o         = cell_q;
  assign atom_o         = atom4_q;

endmodule

`default_nettype wire

FILE: hdl/cell_list_binning_core.sv
// ----------------------------------------------------------------------------
// Cell list binning core
// Builds a linked-cell list: each inserted atom is binned into a cell of a
// cubic box and linked in front of that cell's current head.
// ----------------------------------------------------------------------------
// Usage:
// - Command channel: an item is taken at a clock edge with start high and
//   busy low. mode 1 inserts atom_index_i at pos_x_i/pos_y_i/pos_z_i
//   (unsigned Q8.16); mode 0 empties every cell head.
// - Result channel: done_o is high for one cycle with cell_index_o,
//   previous_head_o, previous_empty_o and coordinate_clamped_o. The
//   receiver cannot stall; every result must be taken in that cycle.
// - Configuration: cfg_we_i writes cfg_wdata_i to register cfg_index_i
//   (0 cells per axis, 1 reciprocal cell length) in the same edge. The user
//   must write only while idle; the block itself does not enforce this.
// - Insert: the item passes the four-stage binning pipeline and then the
//   read-modify-write of the head memory (a registered read, then a write),
//   after which done_o rises; busy falls with it, so items never overlap.
// - Clear: the head memory is swept one cell per cycle; done_o rises with
//   an all-zero result when the last cell is emptied, and busy falls with it.
// - Reset: a clearing pass over all MAX_CELLS_PER_DIM**3 cells (4096 with the
//   default parameters) runs with busy high and gives no result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "cell_list_binning_core_assert.svh"

module cell_list_binning_core
  import clb_pkg::*;
#(
  parameter int unsigned MAX_CELLS_PER_DIM = 16,
  parameter int unsigned MAX_ATOMS         = 4096
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic                  mode_i,
  input  wire logic [ATOM_IDX_W-1:0] atom_index_i,
  input  wire logic [POS_W-1:0]      pos_x_i,
  input  wire logic [POS_W-1:0]      pos_y_i,
  input  wire logic [POS_W-1:0]      pos_z_i,
  output logic                       done_o,
  output logic      [CELL_IDX_W-1:0] cell_index_o,
  output logic      [ATOM_IDX_W-1:0] previous_head_o,
  output logic                       previous_empty_o,
  output logic                       coordinate_clamped_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned N_W       = $clog2(MAX_CELLS_PER_DIM + 1);
  localparam int unsigned NUM_CELLS = MAX_CELLS_PER_DIM ** 3;
  localparam int unsigned CELL_W    = (MAX_CELLS_PER_DIM > 1) ? $clog2(NUM_CELLS) : 1;
  localparam int unsigned ATOM_W    = $clog2(MAX_ATOMS);
  localparam int unsigned ENTRY_W   = ATOM_W + 1;

  clb_state_e state_q, state_d;

  logic [CPD_W-1:0]   cpd_q;
  logic [RECIP_W-1:0] recip_q;
  logic [N_W-1:0]     n_eff;
  logic [N_W-1:0]     n_q;

  logic              accept;
  logic              bin_start;
  clb_bin_stat_t     bin_stat;
  logic [CELL_W-1:0] bin_cell;
  logic [ATOM_W-1:0] bin_atom;

  logic [CELL_W-1:0] sweep_q, sweep_d;
  logic              sweep_last;
  logic              report_clr_q, report_clr_d;

  logic               head_we;
  logic [CELL_W-1:0]  head_waddr;
  logic [ENTRY_W-1:0] head_wdata;
  logic               head_re;
  logic [ENTRY_W-1:0] head_rdata;
  logic               head_valid;
  logic [ATOM_W-1:0]  head_atom;

  logic               link_we;
  logic [ENTRY_W-1:0] link_wdata;
  logic [ENTRY_W-1:0] link_mem [MAX_ATOMS];

  logic                  done_d, done_q;
  logic [CELL_IDX_W-1:0] cell_index_d, cell_index_q;
  logic [ATOM_IDX_W-1:0] prev_head_d, prev_head_q;
  logic                  prev_empty_d, prev_empty_q;
  logic                  clamped_d, clamped_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpd_q   <= CPD_RESET;
      recip_q <= RECIP_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_CELLS_PER_DIM:     cpd_q   <= cfg_wdata_i[CPD_W-1:0];
        CFG_RECIP_CELL_LENGTH: recip_q <= cfg_wdata_i[RECIP_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective cells per axis: zero acts as one, large values saturate.
  always_comb begin
    if (cpd_q == '0) begin
      n_eff = N_W'(1);
    end else if (32'(cpd_q) > MAX_CELLS_PER_DIM) begin
      n_eff = N_W'(MAX_CELLS_PER_DIM);
    end else begin
      n_eff = N_W'(cpd_q);
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_eff;
  end

  // Command handshake.
  assign busy      = (state_q != ST_IDLE);
  assign accept    = start && !busy;
  assign bin_start = accept && (mode_i == MODE_INSERT);

  // Binning pipeline.
  clb_bin_calc #(
    .MAX_CELLS_PER_DIM (MAX_CELLS_PER_DIM),
    .MAX_ATOMS         (MAX_ATOMS)
  ) u_bin_calc (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (bin_start),
    .atom_index_i (atom_index_i),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .pos_z_i      (pos_z_i),
    .recip_i      (recip_q),
    .n_i          (n_q),
    .stat_o       (bin_stat),
    .cell_o       (bin_cell),
    .atom_o       (bin_atom)
  );

  // Cell head memory: valid bit over the head atom.
  clb_head_ram #(
    .DEPTH (NUM_CELLS),
    .WIDTH (ENTRY_W)
  ) u_head_ram (
    .clk_i   (clk_i),
    .we_i    (head_we),
    .waddr_i (head_waddr),
    .wdata_i (head_wdata),
    .re_i    (head_re),
    .raddr_i (bin_cell),
    .rdata_o (head_rdata)
  );

  assign head_valid = head_rdata[ATOM_W];
  assign head_atom  = head_rdata[ATOM_W-1:0];
  assign sweep_last = (sweep_q == CELL_W'(NUM_CELLS - 1));

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (mode_i == MODE_INSERT) ? ST_BIN : ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        if (sweep_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_BIN: begin
        if (bin_stat.done) begin
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Output and datapath control.
  always_comb begin
    head_we      = 1'b0;
    head_waddr   = bin_cell;
    head_wdata   = {1'b1, bin_atom};
    head_re      = 1'b0;
    link_we      = 1'b0;
    link_wdata   = {head_valid, head_valid ? head_atom : '0};
    sweep_d      = sweep_q;
    report_clr_d = report_clr_q;
    done_d       = 1'b0;
    cell_index_d = '0;
    prev_head_d  = '0;
    prev_empty_d = 1'b0;
    clamped_d    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (mode_i == MODE_CLEAR)) begin
          sweep_d      = '0;
          report_clr_d = 1'b1;
        end
      end
      ST_CLEAR: begin
        // One cell emptied per cycle; a clear item reports all zeros.
        head_we    = 1'b1;
        head_waddr = sweep_q;
        head_wdata = '0;
        sweep_d    = sweep_q + 1'b1;
        if (sweep_last) begin
          done_d       = report_clr_q;
          report_clr_d = 1'b0;
        end
      end
      ST_BIN: begin
        head_re = bin_stat.done;
      end
      ST_LOOKUP: begin
        // Old head read back: link it behind the new atom and replace it.
        head_we      = 1'b1;
        link_we      = 1'b1;
        done_d       = 1'b1;
        cell_index_d = CELL_IDX_W'(bin_cell);
        prev_head_d  = head_valid ? ATOM_IDX_W'(head_atom) : '0;
        prev_empty_d = !head_valid;
        clamped_d    = bin_stat.clamped;
      end
      default: ;
    endcase
  end

  // Control registers; reset starts the clearing pass with no result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      sweep_q      <= '0;
      report_clr_q <= 1'b0;
      done_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      sweep_q      <= sweep_d;
      report_clr_q <= report_clr_d;
      done_q       <= done_d;
    end
  end

  // Result payload registers.
  always_ff @(posedge clk_i) begin
    if (done_d) begin
      cell_index_q <= cell_index_d;
      prev_head_q  <= prev_head_d;
      prev_empty_q <= prev_empty_d;
      clamped_q    <= clamped_d;
    end
  end

  // Next-atom links: written on every insert.
  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[bin_atom] <= link_wdata;
    end
  end

  assign done_o               = done_q;
  assign cell_index_o         = cell_index_q;
  assign previous_head_o      = prev_head_q;
  assign previous_empty_o     = prev_empty_q;
  assign coordinate_clamped_o = clamped_q;

  // Assertions.
  `CLB_ASSERT(a_lookup_gives_result, clk_i, rst_ni, (state_q == ST_LOOKUP) |=> done_o)
  `CLB_ASSERT(a_empty_head_zero, clk_i, rst_ni, done_o |-> !(previous_empty_o && (previous_head_o != '0)))
  `CLB_ASSERT_NEVER(a_head_rw_overlap, clk_i, rst_ni, head_we && head_re)
  `CLB_ASSERT(a_bin_done_in_bin, clk_i, rst_ni, bin_stat.done |-> (state_q == ST_BIN))

endmodule

`default_nettype wire
